>>> rtl/ims_pkg.sv
// Package for the I2C master/slave sequencer: item kinds, bus status codes,
// flag bits, completion kinds, mode and data-select types, buffer sizes and the result word type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ims_pkg;

    localparam int MASTER_DEPTH = 16;
    localparam int SLAVE_RX_LEN = 16;
    localparam int SLAVE_TX_LEN = 16;
    localparam int BUF_AW       = 4;

    localparam logic [2:0] KIND_WRITE  = 3'd0;
    localparam logic [2:0] KIND_READ   = 3'd1;
    localparam logic [2:0] KIND_MLOAD  = 3'd2;
    localparam logic [2:0] KIND_TLOAD  = 3'd3;
    localparam logic [2:0] KIND_STATUS = 3'd4;

    localparam logic [7:0] ST_MASK     = 8'hF8;
    localparam logic [7:0] ST_BUS_ERR  = 8'h00;
    localparam logic [7:0] ST_START    = 8'h08;
    localparam logic [7:0] ST_RESTART  = 8'h10;
    localparam logic [7:0] ST_W_ACK    = 8'h18;
    localparam logic [7:0] ST_W_NACK   = 8'h20;
    localparam logic [7:0] ST_DW_ACK   = 8'h28;
    localparam logic [7:0] ST_DW_NACK  = 8'h30;
    localparam logic [7:0] ST_LOST     = 8'h38;
    localparam logic [7:0] ST_R_ACK    = 8'h40;
    localparam logic [7:0] ST_R_NACK   = 8'h48;
    localparam logic [7:0] ST_DR_ACK   = 8'h50;
    localparam logic [7:0] ST_DR_NACK  = 8'h58;
    localparam logic [7:0] ST_SR_ADDR  = 8'h60;
    localparam logic [7:0] ST_SR_LOST  = 8'h68;
    localparam logic [7:0] ST_SR_GADDR = 8'h70;
    localparam logic [7:0] ST_SR_GLOST = 8'h78;
    localparam logic [7:0] ST_SR_DATA  = 8'h80;
    localparam logic [7:0] ST_SR_LAST  = 8'h88;
    localparam logic [7:0] ST_SR_GDATA = 8'h90;
    localparam logic [7:0] ST_SR_GLAST = 8'h98;
    localparam logic [7:0] ST_SR_STOP  = 8'hA0;
    localparam logic [7:0] ST_ST_ADDR  = 8'hA8;
    localparam logic [7:0] ST_ST_LOST  = 8'hB0;
    localparam logic [7:0] ST_ST_ACK   = 8'hB8;
    localparam logic [7:0] ST_ST_NACK  = 8'hC0;
    localparam logic [7:0] ST_ST_LAST  = 8'hC8;

    localparam logic [7:0] F_BUSY = 8'h01;
    localparam logic [7:0] F_INTR = 8'h02;
    localparam logic [7:0] F_BERR = 8'h04;
    localparam logic [7:0] F_NA   = 8'h08;
    localparam logic [7:0] F_NACK = 8'h10;
    localparam logic [7:0] F_LP   = 8'h20;

    localparam logic [2:0] COMP_NONE  = 3'd0;
    localparam logic [2:0] COMP_MDONE = 3'd1;
    localparam logic [2:0] COMP_MERR  = 3'd2;
    localparam logic [2:0] COMP_SRX   = 3'd3;
    localparam logic [2:0] COMP_STX   = 3'd4;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_READ  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        DSEL_REG    = 2'd0,
        DSEL_MASTER = 2'd1,
        DSEL_TX     = 2'd2
    } dsel_t;

    typedef struct packed {
        logic       accepted;
        logic       send_start;
        logic       send_stop;
        logic       ack_enable;
        logic       advance;
        logic       drive_valid;
        logic [7:0] drive_byte;
        logic       rx_valid;
        logic [3:0] rx_index;
        logic [7:0] rx_byte;
        logic [2:0] completion;
        logic [7:0] status_flags;
    } rsp_t;

endpackage
`default_nettype wire

>>> rtl/ims_req_if.sv
// Input item channel of the sequencer: valid/ready plus the item fields.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface ims_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] target_address;
    logic [4:0] byte_count;
    logic [3:0] entry_index;
    logic [7:0] entry_value;
    logic [7:0] status_code;
    logic [7:0] bus_byte;

    modport source (output valid, kind, target_address, byte_count, entry_index,
                    entry_value, status_code, bus_byte, input ready);
    modport sink (input valid, kind, target_address, byte_count, entry_index,
                  entry_value, status_code, bus_byte, output ready);
endinterface
`default_nettype wire

>>> rtl/ims_rsp_if.sv
// Result channel of the sequencer: valid/ready plus the result fields.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface ims_rsp_if;
    logic       valid;
    logic       ready;
    logic       accepted;
    logic       send_start;
    logic       send_stop;
    logic       ack_enable;
    logic       advance;
    logic       drive_valid;
    logic [7:0] drive_byte;
    logic       rx_valid;
    logic [3:0] rx_index;
    logic [7:0] rx_byte;
    logic [2:0] completion;
    logic [7:0] status_flags;

    modport source (output valid, accepted, send_start, send_stop, ack_enable, advance,
                    drive_valid, drive_byte, rx_valid, rx_index, rx_byte, completion,
                    status_flags, input ready);
    modport sink (input valid, accepted, send_start, send_stop, ack_enable, advance,
                  drive_valid, drive_byte, rx_valid, rx_index, rx_byte, completion,
                  status_flags, output ready);
endinterface
`default_nettype wire

>>> rtl/ims_cfg_if.sv
// Configuration write channel: valid/ready plus the slave_enable word.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface ims_cfg_if;
    logic valid;
    logic ready;
    logic slave_enable;

    modport source (output valid, slave_enable, input ready);
    modport sink (input valid, slave_enable, output ready);
endinterface
`default_nettype wire

>>> rtl/ims_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ims_ram #(
    parameter int AW = 4,
    parameter int DW = 8
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);
    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

>>> rtl/i2c_master_slave_sequencer.sv
// Top level of the I2C master/slave sequencer; uses ims_pkg, ims_ram and the
// ims_req_if, ims_rsp_if and ims_cfg_if channel interfaces.
// Stages: a result passes the buffer read stage, then the output register.
// Throughput: one word per cycle unless rsp.ready holds the output, set by
// the single read port of the master and TX buffer RAMs, read once per word.
// Reset: control state, flags and positions clear at once; buffers hold
// nothing defined until loaded, and no clearing pass runs.
`timescale 1ns / 1ps
`default_nettype none
module i2c_master_slave_sequencer
    import ims_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    ims_req_if.sink   req,
    ims_rsp_if.source rsp,
    ims_cfg_if.sink   cfg
);
    localparam logic [5:0] M_LIM  = 6'(MASTER_DEPTH);
    localparam logic [5:0] RX_LIM = 6'(SLAVE_RX_LEN);
    localparam logic [5:0] TX_LIM = 6'(SLAVE_TX_LEN);
    localparam logic       RX_ACK0 = (SLAVE_RX_LEN == 1) ? 1'b0 : 1'b1;
    localparam logic       TX_ACK0 = (SLAVE_TX_LEN == 1) ? 1'b0 : 1'b1;

    // Scalar state; all but se_reg update as each word is accepted
    logic       se_reg;
    mode_t      mode_reg, mode_next;
    logic [7:0] flags_reg, flags_next;
    logic [7:0] addr_reg, addr_next;
    logic [4:0] mpos_reg, mpos_next;
    logic [4:0] mcnt_reg, mcnt_next;
    logic [4:0] spos_reg, spos_next;

    // Read stage: result with the driven byte still pending from a buffer
    logic  s1_valid_reg;
    rsp_t  s1_reg, s1_next;
    dsel_t s1_dsel_reg, s1_dsel_next;
    logic  s1_dzero_reg, s1_dzero_next;

    // Output register
    logic o_valid_reg;
    rsp_t o_reg, o_next;

    logic s1_adv, req_fire;

    // Buffer ports
    logic              m_we, t_we, r_we;
    logic [BUF_AW-1:0] m_wa, t_wa, r_wa, m_ra, t_ra;
    logic [7:0]        m_wd, t_wd, r_wd, m_rd, t_rd, r_unused;

    assign cfg.ready = 1'b1;
    assign s1_adv    = !o_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || s1_adv;
    assign req_fire  = req.valid && req.ready;

    ims_ram #(.AW(BUF_AW), .DW(8)) u_master_buf (
        .clk(clk), .we(m_we && req_fire), .waddr(m_wa), .wdata(m_wd),
        .re(req_fire), .raddr(m_ra), .rdata(m_rd)
    );
    ims_ram #(.AW(BUF_AW), .DW(8)) u_tx_buf (
        .clk(clk), .we(t_we && req_fire), .waddr(t_wa), .wdata(t_wd),
        .re(req_fire), .raddr(t_ra), .rdata(t_rd)
    );
    // Slave receive buffer is written only; the received bytes leave via rx_byte
    ims_ram #(.AW(BUF_AW), .DW(8)) u_rx_buf (
        .clk(clk), .we(r_we && req_fire), .waddr(r_wa), .wdata(r_wd),
        .re(1'b0), .raddr(r_wa), .rdata(r_unused)
    );

    // Decode one word against the current state
    always_comb
    begin
        logic [7:0] fl;
        logic [7:0] a;
        logic [4:0] np;
        logic       mfin;
        logic       sfin;
        s1_next       = '0;
        s1_dsel_next  = DSEL_REG;
        s1_dzero_next = 1'b0;
        mode_next  = mode_reg;
        flags_next = flags_reg;
        addr_next  = addr_reg;
        mpos_next  = mpos_reg;
        mcnt_next  = mcnt_reg;
        spos_next  = spos_reg;
        m_we = 1'b0;
        t_we = 1'b0;
        r_we = 1'b0;
        m_wa = req.entry_index;
        m_wd = req.entry_value;
        t_wa = req.entry_index;
        t_wd = req.entry_value;
        r_wa = spos_reg[BUF_AW-1:0];
        r_wd = req.bus_byte;
        m_ra = mpos_reg[BUF_AW-1:0];
        t_ra = '0;
        fl   = flags_reg;
        a    = addr_reg;
        np   = '0;
        mfin = 1'b0;
        sfin = 1'b0;

        unique case (req.kind)
            KIND_WRITE, KIND_READ:
            begin
                if ((flags_reg & F_BUSY) == 8'h00)
                begin
                    mpos_next  = '0;
                    addr_next  = req.target_address;
                    mcnt_next  = req.byte_count;
                    mode_next  = (req.kind == KIND_WRITE) ? MODE_WRITE : MODE_READ;
                    flags_next = F_BUSY;
                    fl         = F_BUSY;
                    s1_next.accepted   = 1'b1;
                    s1_next.send_start = 1'b1;
                    s1_next.advance    = 1'b1;
                end
            end
            KIND_MLOAD:
            begin
                m_we = ({2'b00, req.entry_index} < M_LIM);
            end
            KIND_TLOAD:
            begin
                t_we = ({2'b00, req.entry_index} < TX_LIM);
            end
            KIND_STATUS:
            begin
                unique case (req.status_code & ST_MASK)
                    ST_BUS_ERR:
                    begin
                        fl = fl | F_BERR;
                        s1_next.send_stop  = 1'b1;
                        s1_next.ack_enable = se_reg;
                        s1_next.advance    = 1'b1;
                        s1_next.completion = COMP_MERR;
                        mfin = 1'b1;
                    end
                    ST_START, ST_RESTART:
                    begin
                        a = (mode_reg == MODE_READ) ? (addr_reg | 8'h01) : (addr_reg & 8'hFE);
                        addr_next = a;
                        s1_next.drive_valid = 1'b1;
                        s1_next.drive_byte  = a;
                        s1_next.ack_enable  = se_reg;
                        s1_next.advance     = 1'b1;
                    end
                    ST_W_ACK, ST_DW_ACK:
                    begin
                        if (mode_reg == MODE_WRITE)
                        begin
                            // Data-ack with the count reached ends the write
                            if ((req.status_code & ST_MASK) == ST_DW_ACK && mpos_reg >= mcnt_reg)
                            begin
                                s1_next.send_stop  = 1'b1;
                                s1_next.ack_enable = se_reg;
                                s1_next.advance    = 1'b1;
                                s1_next.completion = COMP_MDONE;
                                mfin = 1'b1;
                            end
                            else
                            begin
                                s1_dsel_next  = DSEL_MASTER;
                                s1_dzero_next = !({1'b0, mpos_reg} < M_LIM);
                                s1_next.drive_valid = 1'b1;
                                mpos_next = (mpos_reg == 5'd31) ? mpos_reg : mpos_reg + 5'd1;
                                s1_next.ack_enable = se_reg;
                                s1_next.advance    = 1'b1;
                            end
                        end
                    end
                    ST_W_NACK, ST_R_NACK:
                    begin
                        fl = fl | F_NA;
                        s1_next.send_stop  = 1'b1;
                        s1_next.ack_enable = se_reg;
                        s1_next.advance    = 1'b1;
                        s1_next.completion = COMP_MERR;
                        mfin = 1'b1;
                    end
                    ST_DW_NACK:
                    begin
                        fl = fl | F_NACK;
                        s1_next.send_stop  = 1'b1;
                        s1_next.ack_enable = se_reg;
                        s1_next.advance    = 1'b1;
                        s1_next.completion = COMP_MDONE;
                        mfin = 1'b1;
                    end
                    ST_LOST:
                    begin
                        fl = fl | F_LP;
                        mpos_next = '0;
                        s1_next.send_start = 1'b1;
                        s1_next.ack_enable = se_reg;
                        s1_next.advance    = 1'b1;
                    end
                    ST_R_ACK:
                    begin
                        s1_next.ack_enable =
                            !(({1'b0, mpos_reg} + 6'd1) >= {1'b0, mcnt_reg});
                        s1_next.advance = 1'b1;
                    end
                    ST_DR_ACK, ST_DR_NACK:
                    begin
                        m_we = ({1'b0, mpos_reg} < M_LIM);
                        m_wa = mpos_reg[BUF_AW-1:0];
                        m_wd = req.bus_byte;
                        s1_next.rx_valid = 1'b1;
                        s1_next.rx_index = mpos_reg[3:0];
                        s1_next.rx_byte  = req.bus_byte;
                        s1_next.advance  = 1'b1;
                        if ((req.status_code & ST_MASK) == ST_DR_ACK)
                        begin
                            np = (mpos_reg == 5'd31) ? mpos_reg : mpos_reg + 5'd1;
                            mpos_next = np;
                            s1_next.ack_enable = !(({1'b0, np} + 6'd1) >= {1'b0, mcnt_reg});
                        end
                        else
                        begin
                            s1_next.send_stop  = 1'b1;
                            s1_next.ack_enable = se_reg;
                            s1_next.completion = COMP_MDONE;
                            mfin = 1'b1;
                        end
                    end
                    ST_SR_LOST, ST_SR_GLOST, ST_SR_ADDR, ST_SR_GADDR:
                    begin
                        if ((req.status_code & ST_MASK) == ST_SR_LOST ||
                            (req.status_code & ST_MASK) == ST_SR_GLOST)
                        begin
                            fl = fl | F_LP | F_INTR;
                            mpos_next = '0;
                        end
                        fl = fl | F_BUSY;
                        spos_next = '0;
                        s1_next.ack_enable = RX_ACK0;
                        s1_next.advance    = 1'b1;
                    end
                    ST_SR_DATA, ST_SR_GDATA, ST_SR_LAST, ST_SR_GLAST:
                    begin
                        r_we = ({1'b0, spos_reg} < RX_LIM);
                        s1_next.rx_valid = 1'b1;
                        s1_next.rx_index = spos_reg[3:0];
                        s1_next.rx_byte  = req.bus_byte;
                        if ((req.status_code & ST_MASK) == ST_SR_DATA ||
                            (req.status_code & ST_MASK) == ST_SR_GDATA)
                        begin
                            np = (spos_reg == 5'd31) ? spos_reg : spos_reg + 5'd1;
                            spos_next = np;
                            s1_next.ack_enable = !(({1'b0, np} + 6'd1) >= RX_LIM);
                            s1_next.advance    = 1'b1;
                        end
                        else
                        begin
                            s1_next.completion = COMP_SRX;
                            sfin = 1'b1;
                        end
                    end
                    ST_SR_STOP:
                    begin
                        s1_next.ack_enable = 1'b1;
                        s1_next.advance    = 1'b1;
                    end
                    ST_ST_LOST, ST_ST_ADDR:
                    begin
                        if ((req.status_code & ST_MASK) == ST_ST_LOST)
                        begin
                            fl = fl | F_LP | F_INTR;
                            mpos_next = '0;
                        end
                        spos_next = '0;
                        s1_dsel_next = DSEL_TX;
                        t_ra = '0;
                        s1_next.drive_valid = 1'b1;
                        s1_next.ack_enable  = TX_ACK0;
                        s1_next.advance     = 1'b1;
                    end
                    ST_ST_ACK:
                    begin
                        np = (spos_reg == 5'd31) ? spos_reg : spos_reg + 5'd1;
                        spos_next = np;
                        s1_dsel_next  = DSEL_TX;
                        s1_dzero_next = !({1'b0, np} < TX_LIM);
                        t_ra = np[BUF_AW-1:0];
                        s1_next.drive_valid = 1'b1;
                        s1_next.ack_enable  = !(({1'b0, np} + 6'd1) >= TX_LIM);
                        s1_next.advance     = 1'b1;
                    end
                    ST_ST_NACK, ST_ST_LAST:
                    begin
                        s1_next.completion = COMP_STX;
                        sfin = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        // Report flags after this word's update, before any completion clears them
        s1_next.status_flags = fl;
        flags_next = (req.kind == KIND_STATUS) ? fl : flags_next;
        if (mfin)
        begin
            flags_next = '0;
            mode_next  = MODE_IDLE;
        end
        if (sfin)
        begin
            // On slave completion, resume an interrupted master transfer with a fresh start; else go idle
            s1_next.ack_enable = 1'b1;
            s1_next.advance    = 1'b1;
            if ((fl & F_INTR) != 8'h00)
            begin
                flags_next = fl & ~F_INTR;
                s1_next.send_start = 1'b1;
            end
            else
            begin
                flags_next = '0;
                mode_next  = MODE_IDLE;
            end
        end
    end

    // Merge the buffer read data into the result
    always_comb
    begin
        o_next = s1_reg;
        unique case (s1_dsel_reg)
            DSEL_MASTER: o_next.drive_byte = s1_dzero_reg ? 8'h00 : m_rd;
            DSEL_TX:     o_next.drive_byte = s1_dzero_reg ? 8'h00 : t_rd;
            default:     o_next.drive_byte = s1_reg.drive_byte;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            se_reg       <= 1'b0;
            mode_reg     <= MODE_IDLE;
            flags_reg    <= '0;
            addr_reg     <= '0;
            mpos_reg     <= '0;
            mcnt_reg     <= '0;
            spos_reg     <= '0;
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                se_reg <= cfg.slave_enable;
            end
            if (req_fire)
            begin
                mode_reg  <= mode_next;
                flags_reg <= flags_next;
                addr_reg  <= addr_next;
                mpos_reg  <= mpos_next;
                mcnt_reg  <= mcnt_next;
                spos_reg  <= spos_next;
            end
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (s1_adv)
            begin
                o_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload registers: load on advance, no reset
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_reg       <= s1_next;
            s1_dsel_reg  <= s1_dsel_next;
            s1_dzero_reg <= s1_dzero_next;
        end
        if (s1_adv && s1_valid_reg)
        begin
            o_reg <= o_next;
        end
    end

    assign rsp.valid        = o_valid_reg;
    assign rsp.accepted     = o_reg.accepted;
    assign rsp.send_start   = o_reg.send_start;
    assign rsp.send_stop    = o_reg.send_stop;
    assign rsp.ack_enable   = o_reg.ack_enable;
    assign rsp.advance      = o_reg.advance;
    assign rsp.drive_valid  = o_reg.drive_valid;
    assign rsp.drive_byte   = o_reg.drive_byte;
    assign rsp.rx_valid     = o_reg.rx_valid;
    assign rsp.rx_index     = o_reg.rx_index;
    assign rsp.rx_byte      = o_reg.rx_byte;
    assign rsp.completion   = o_reg.completion;
    assign rsp.status_flags = o_reg.status_flags;
endmodule
`default_nettype wire
